### sv/cwps_pkg.sv
// ----------------------------------------------------------------------------
// Clock wipe pixel select package
// Shared widths, word types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package cwps_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int PROG_W     = 17;
  localparam int PIXEL_W    = 32;
  localparam int OFS_W      = 15;  // doubled offset from the frame center
  localparam int VEC_SHIFT  = 16;
  localparam int VEC_W      = 33;  // scaled vector with room for CORDIC gain
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int MAX_STEPS  = 28;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PROGRESS = 2'd2;

  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [PROG_W-1:0] PROGRESS_RESET     = 17'd0;

  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [PIXEL_W-1:0] old_pixel;
    logic [PIXEL_W-1:0] new_pixel;
  } cwps_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] shown_pixel;
    logic               took_new;
  } cwps_out_t;

  // Payload handed from one CORDIC cell to the next.
  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [ACC_W-1:0]        acc;
    logic [PIXEL_W-1:0]      old_pixel;
    logic [PIXEL_W-1:0]      new_pixel;
  } cwps_vec_t;

  // atan(2^-step) as a fraction of a turn, scaled by 2^32.
  function automatic logic [ACC_W-1:0] turn_atan(input int step);
    logic [ACC_W-1:0] val;
    case (step)
      0:       val = 32'h2000_0000;
      1:       val = 32'h12E4_051E;
      2:       val = 32'h09FB_385B;
      3:       val = 32'h0511_11D4;
      4:       val = 32'h028B_0D43;
      5:       val = 32'h0145_D7E1;
      6:       val = 32'h00A2_F61E;
      7:       val = 32'h0051_7C55;
      8:       val = 32'h0028_BE53;
      9:       val = 32'h0014_5F2F;
      10:      val = 32'h000A_2F98;
      11:      val = 32'h0005_17CC;
      12:      val = 32'h0002_8BE6;
      13:      val = 32'h0001_45F3;
      14:      val = 32'h0000_A2FA;
      15:      val = 32'h0000_517D;
      16:      val = 32'h0000_28BE;
      17:      val = 32'h0000_145F;
      18:      val = 32'h0000_0A30;
      19:      val = 32'h0000_0518;
      20:      val = 32'h0000_028C;
      21:      val = 32'h0000_0146;
      22:      val = 32'h0000_00A3;
      23:      val = 32'h0000_0051;
      24:      val = 32'h0000_0029;
      25:      val = 32'h0000_0014;
      26:      val = 32'h0000_000A;
      27:      val = 32'h0000_0005;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### sv/cwps_front.sv
// ----------------------------------------------------------------------------
// Clock wipe front end
// Turns a pixel position into a vector about the frame center, folded into
// the right half plane, and registers it with the pixel pair.
// ----------------------------------------------------------------------------
`default_nettype none

module cwps_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  cwps_pkg::cwps_in_t          in_word,
  input  logic [cwps_pkg::DIM_W-1:0]  frame_width,
  input  logic [cwps_pkg::DIM_W-1:0]  frame_height,
  output logic                        vld,
  output cwps_pkg::cwps_vec_t         vec
);
  import cwps_pkg::*;

  logic [DIM_W-1:0]        w_sat;
  logic [DIM_W-1:0]        h_sat;
  logic signed [OFS_W-1:0] u;
  logic signed [OFS_W-1:0] v;
  logic signed [OFS_W-1:0] fx;
  logic signed [OFS_W-1:0] fy;
  cwps_vec_t               vec_next;

  always_comb begin
    w_sat = (32'(frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_width;
    h_sat = (32'(frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_height;
    // Doubled coordinates keep a half-pixel center exact.
    u = $signed({2'b00, in_word.pixel_column, 1'b0}) - $signed({2'b00, w_sat});
    v = $signed({2'b00, h_sat}) - $signed({2'b00, in_word.pixel_row, 1'b0});
    vec_next.zero      = (u == '0) && (v == '0);
    vec_next.old_pixel = in_word.old_pixel;
    vec_next.new_pixel = in_word.new_pixel;
    // The vector is (v, u) so that 12 o'clock lies on the x axis.
    if (v[OFS_W-1]) begin
      fx           = -v;
      fy           = -u;
      vec_next.acc = HALF_TURN;
    end else begin
      fx           = v;
      fy           = u;
      vec_next.acc = '0;
    end
    vec_next.x = {{(VEC_W-OFS_W-VEC_SHIFT){fx[OFS_W-1]}}, fx, {VEC_SHIFT{1'b0}}};
    vec_next.y = {{(VEC_W-OFS_W-VEC_SHIFT){fy[OFS_W-1]}}, fy, {VEC_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec <= vec_next;
    end
  end

endmodule

`default_nettype wire

### sv/cwps_cell.sv
// ----------------------------------------------------------------------------
// Clock wipe CORDIC cell
// One vectoring step: rotates the vector toward the x axis by a fixed angle
// and keeps the turn count, then hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cwps_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                prev_vld,
  input  cwps_pkg::cwps_vec_t prev_vec,
  output logic                vld,
  output cwps_pkg::cwps_vec_t vec
);
  import cwps_pkg::*;

  localparam logic [ACC_W-1:0] ATAN = turn_atan(STEP);

  logic signed [VEC_W-1:0] sx;
  logic signed [VEC_W-1:0] sy;
  cwps_vec_t               vec_next;

  always_comb begin
    vec_next = prev_vec;
    // Arithmetic shift rounds toward minus infinity.
    sx = prev_vec.x >>> STEP;
    sy = prev_vec.y >>> STEP;
    if (!prev_vec.y[VEC_W-1]) begin
      vec_next.x   = prev_vec.x + sy;
      vec_next.y   = prev_vec.y - sx;
      vec_next.acc = prev_vec.acc + ATAN;
    end else begin
      vec_next.x   = prev_vec.x - sy;
      vec_next.y   = prev_vec.y + sx;
      vec_next.acc = prev_vec.acc - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec <= vec_next;
    end
  end

endmodule

`default_nettype wire

### sv/clock_wipe_pixel_select_core.sv
// Pipeline from input word to output word: one front stage, ANGLE_BITS + 4
// CORDIC cells, one select register.
// Throughput: one word per cycle; a stalled output freezes the whole chain.
// Reset clears all valid bits and loads frame 640 x 480 with progress zero.
// ----------------------------------------------------------------------------
// Clock wipe pixel select core
// Picks the incoming or outgoing pixel by its clockwise angle from 12 o'clock
// about the frame center, against the configured sweep progress.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_wipe_pixel_select_core #(
  parameter int MAX_DIM    = 4096,
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cwps_pkg::cwps_in_t               in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cwps_pkg::cwps_out_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cwps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cwps_pkg::*;

  localparam int STEPS = ANGLE_BITS + 4;
  localparam int CMP_W = ANGLE_BITS + PROG_W;

  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic [PROG_W-1:0]     sweep_progress;
  logic                  adv;
  logic                  chain_vld [0:STEPS];
  cwps_vec_t             chain_vec [0:STEPS];
  logic [ACC_W-1:0]      acc_round;
  logic [ANGLE_BITS-1:0] angle;
  logic                  take_new;
  cwps_out_t             out_word_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      sweep_progress <= PROGRESS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[DIM_W-1:0];
        REG_SWEEP_PROGRESS: sweep_progress <= cfg_data[PROG_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is free or being drained.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  cwps_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_word      (in_word),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .vld          (chain_vld[0]),
    .vec          (chain_vec[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    cwps_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .prev_vld (chain_vld[i]),
      .prev_vec (chain_vec[i]),
      .vld      (chain_vld[i+1]),
      .vec      (chain_vec[i+1])
    );
  end

  always_comb begin
    acc_round = chain_vec[STEPS].acc + (ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS));
    // The center pixel has no direction and counts as angle zero.
    angle = chain_vec[STEPS].zero ? '0 : acc_round[ACC_W-1 -: ANGLE_BITS];
    take_new = CMP_W'({angle, {VEC_SHIFT{1'b0}}})
             < {sweep_progress, {ANGLE_BITS{1'b0}}};
    out_word_next.took_new    = take_new;
    out_word_next.shown_pixel = take_new ? chain_vec[STEPS].new_pixel
                                         : chain_vec[STEPS].old_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= out_word_next;
    end
  end

endmodule

`default_nettype wire
